>>> sv/bcat_pkg.sv
// Shared constants for the block chain allocation table.
package bcat_pkg;

   localparam int BLK_W      = 6;
   localparam int ENTRY_W    = 8;
   localparam int ACT_W      = 7;
   localparam int BPB_W      = 11;
   localparam int ADDR_W     = 16;
   localparam int FREED_W    = 7;
   localparam int STATUS_W   = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // table entry codes; anything below ENT_ALLOC is a link
   localparam logic [ENTRY_W-1:0] ENT_FREE  = 8'hFF;
   localparam logic [ENTRY_W-1:0] ENT_EOF   = 8'hFE;
   localparam logic [ENTRY_W-1:0] ENT_ALLOC = 8'hFD;

   localparam logic [KIND_W-1:0] OP_APPEND = 2'd0;
   localparam logic [KIND_W-1:0] OP_CLOSE  = 2'd1;
   localparam logic [KIND_W-1:0] OP_FOLLOW = 2'd2;
   localparam logic [KIND_W-1:0] OP_DELETE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD     = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_BLOCKS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_BLOCK = 1'b1;

   localparam logic [ACT_W-1:0] ACTIVE_RESET = 7'd40;
   localparam logic [BPB_W-1:0] BPB_RESET    = 11'd1;

endpackage

>>> sv/bcat_store.sv
// Table entry memory: one write and one registered read port, per-entry valid bits.
module bcat_store
   import bcat_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [ENTRY_W-1:0]         rd_data,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [ENTRY_W-1:0]         wr_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]   valid_ff;
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_valid_ff;

   // old data on a read of the entry being written
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // never-written entries read as free
   assign rd_data = rd_valid_ff ? rd_data_ff : ENT_FREE;

endmodule

>>> sv/block_chain_allocation_table.sv
// Block chain allocation table: top level with sequencer and result registers.
//
// Commands are taken on start while busy is low: req_kind selects append,
// close, follow or delete; req_start_new and req_block qualify it. Each
// command gives one result word, shown for one cycle with rsp_strobe high;
// the receiver cannot stall and must take it then. A new command may be
// issued in the cycle the strobe is shown.
// The table sits in a single-port-write, registered-read memory walked by
// the sequencer one entry a cycle:
//   close and any rejected command: go straight to the finish state;
//   follow: reads the given entry, then finishes;
//   append: scans the first n blocks for the lowest free one, then marks it
//     allocated and links it to the open tail unless a new file is started;
//   delete: frees each block of the chain in turn until it meets a free
//     entry or a code, a link outside the first n blocks, or n blocks freed.
// n is the lesser of active_blocks and TABLE_DEPTH. One command is in
// flight at a time; busy stays high until its result is strobed.
// The csr_ port writes active_blocks or bytes_per_block, as csr_index
// selects, at once; write it only while busy is low. Reset is synchronous:
// all entries read as free at once (per-entry valid bits), no file is open
// and the registers return to 40 and 1.
module block_chain_allocation_table
   import bcat_pkg::*;
#(
   parameter int TABLE_DEPTH = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [KIND_W-1:0]     req_kind,
   input  logic                  req_start_new,
   input  logic [BLK_W-1:0]      req_block,
   output logic                  rsp_strobe,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [BLK_W-1:0]      rsp_block_index,
   output logic [ADDR_W-1:0]     rsp_byte_address,
   output logic                  rsp_at_end,
   output logic [FREED_W-1:0]    rsp_freed_count,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int NW     = (CNT_W > ENTRY_W) ? CNT_W : ENTRY_W;
   localparam int PROD_W = ENTRY_W + BPB_W;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SCAN   = 7'b0000010,
      S_ALLOC  = 7'b0000100,
      S_LINK   = 7'b0001000,
      S_FOLLOW = 7'b0010000,
      S_DELETE = 7'b0100000,
      S_FIN    = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [ACT_W-1:0]     active_ff, active_in;
   logic [BPB_W-1:0]     bpb_ff, bpb_in;
   logic [BLK_W-1:0]     tail_ff, tail_in;
   logic                 open_ff, open_in;
   logic                 start_new_ff, start_new_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]     found_ff, found_in;
   logic [IDX_W-1:0]     cur_ff, cur_in;
   logic                 fwd_ff, fwd_in;
   logic [CNT_W-1:0]     freed_ff, freed_in;
   logic [ENTRY_W-1:0]   mul_op_ff, mul_op_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [BLK_W-1:0]     rsp_block_index_ff, rsp_block_index_in;
   logic [ADDR_W-1:0]    rsp_byte_address_ff, rsp_byte_address_in;
   logic                 rsp_at_end_ff, rsp_at_end_in;
   logic [FREED_W-1:0]   rsp_freed_count_ff, rsp_freed_count_in;

   logic [IDX_W-1:0]     rd_addr;
   logic [ENTRY_W-1:0]   rd_data;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;

   logic [NW-1:0]        n_val;
   logic                 tail_ok;
   logic                 blk_ok;
   logic                 scan_issue;
   logic [ENTRY_W-1:0]   ent;
   logic [CNT_W-1:0]     freed_inc;
   logic [PROD_W-1:0]    prod;

   bcat_store #(
      .DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign n_val = (NW'(active_ff) < NW'(TABLE_DEPTH)) ? NW'(active_ff) : NW'(TABLE_DEPTH);
   assign tail_ok    = open_ff && (NW'(tail_ff) < n_val);
   assign blk_ok     = NW'(req_block) < n_val;
   assign scan_issue = NW'(scan_ff) < n_val;
   // the entry read last cycle may have been freed in that same cycle
   assign ent        = fwd_ff ? ENT_FREE : rd_data;
   assign freed_inc  = freed_ff + CNT_W'(1);
   assign prod       = PROD_W'(mul_op_ff) * PROD_W'(bpb_ff);

   always_comb begin
      state_in            = state_ff;
      active_in           = active_ff;
      bpb_in              = bpb_ff;
      tail_in             = tail_ff;
      open_in             = open_ff;
      start_new_in        = start_new_ff;
      scan_in             = scan_ff;
      chk_idx_in          = chk_idx_ff;
      chk_vld_in          = chk_vld_ff;
      found_in            = found_ff;
      cur_in              = cur_ff;
      fwd_in              = fwd_ff;
      freed_in            = freed_ff;
      mul_op_in           = mul_op_ff;
      rsp_strobe_in       = 1'b0;
      rsp_status_in       = rsp_status_ff;
      rsp_block_index_in  = rsp_block_index_ff;
      rsp_byte_address_in = rsp_byte_address_ff;
      rsp_at_end_in       = rsp_at_end_ff;
      rsp_freed_count_in  = rsp_freed_count_ff;
      rd_addr             = IDX_W'(req_block);
      wr_en               = 1'b0;
      wr_addr             = cur_ff;
      wr_data             = ENT_FREE;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACTIVE_BLOCKS:   active_in = csr_wdata[ACT_W-1:0];
            CSR_BYTES_PER_BLOCK: bpb_in    = csr_wdata[BPB_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_status_in      = ST_OK;
               rsp_block_index_in = '0;
               rsp_at_end_in      = 1'b0;
               rsp_freed_count_in = '0;
               mul_op_in          = '0;
               start_new_in       = req_start_new;
               cur_in             = IDX_W'(req_block);
               fwd_in             = 1'b0;
               freed_in           = '0;
               scan_in            = '0;
               chk_vld_in         = 1'b0;
               state_in           = S_FIN;
               case (req_kind)
                  OP_APPEND: begin
                     if (!req_start_new && !tail_ok) begin
                        rsp_status_in = ST_BAD;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_CLOSE: begin
                     if (!tail_ok) begin
                        rsp_status_in = ST_BAD;
                     end else begin
                        wr_en              = 1'b1;
                        wr_addr            = IDX_W'(tail_ff);
                        wr_data            = ENT_EOF;
                        open_in            = 1'b0;
                        rsp_block_index_in = tail_ff;
                        mul_op_in          = ENTRY_W'(tail_ff);
                     end
                  end
                  OP_FOLLOW: begin
                     if (!blk_ok) begin
                        rsp_status_in = ST_BAD;
                     end else begin
                        state_in = S_FOLLOW;
                     end
                  end
                  OP_DELETE: begin
                     if (!blk_ok) begin
                        rsp_status_in = ST_BAD;
                     end else begin
                        state_in = S_DELETE;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one read issued and one compared each cycle
            rd_addr = IDX_W'(scan_ff);
            if (chk_vld_ff && (rd_data == ENT_FREE)) begin
               found_in = chk_idx_ff;
               state_in = S_ALLOC;
            end else if (!chk_vld_ff && !scan_issue) begin
               rsp_status_in = ST_NO_FREE;
               state_in      = S_FIN;
            end else begin
               chk_vld_in = scan_issue;
               chk_idx_in = IDX_W'(scan_ff);
               if (scan_issue) begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
         end
         S_ALLOC: begin
            wr_en    = 1'b1;
            wr_addr  = found_ff;
            wr_data  = ENT_ALLOC;
            state_in = S_LINK;
         end
         S_LINK: begin
            if (!start_new_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(tail_ff);
               wr_data = ENTRY_W'(found_ff);
            end
            tail_in            = BLK_W'(found_ff);
            open_in            = 1'b1;
            rsp_block_index_in = BLK_W'(found_ff);
            mul_op_in          = ENTRY_W'(found_ff);
            state_in           = S_FIN;
         end
         S_FOLLOW: begin
            if (rd_data == ENT_EOF) begin
               rsp_at_end_in = 1'b1;
            end else if (rd_data < ENT_ALLOC) begin
               rsp_block_index_in = rd_data[BLK_W-1:0];
               mul_op_in          = ENTRY_W'(rd_data[BLK_W-1:0]);
            end
            state_in = S_FIN;
         end
         S_DELETE: begin
            if (ent == ENT_FREE) begin
               rsp_freed_count_in = FREED_W'(freed_ff);
               state_in           = S_FIN;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = cur_ff;
               wr_data  = ENT_FREE;
               freed_in = freed_inc;
               if (open_ff && (NW'(cur_ff) == NW'(tail_ff))) begin
                  open_in = 1'b0;
               end
               // walk ends at a code, a link outside the used range, or n steps
               if ((ent >= ENT_ALLOC) || (NW'(ent) >= n_val) || (NW'(freed_inc) == n_val)) begin
                  rsp_freed_count_in = FREED_W'(freed_inc);
                  state_in           = S_FIN;
               end else begin
                  cur_in  = IDX_W'(ent);
                  rd_addr = IDX_W'(ent);
                  fwd_in  = (IDX_W'(ent) == cur_ff);
               end
            end
         end
         S_FIN: begin
            rsp_byte_address_in = prod[ADDR_W-1:0];
            rsp_strobe_in       = 1'b1;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         active_ff     <= ACTIVE_RESET;
         bpb_ff        <= BPB_RESET;
         tail_ff       <= '0;
         open_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         bpb_ff        <= bpb_in;
         tail_ff       <= tail_in;
         open_ff       <= open_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      start_new_ff        <= start_new_in;
      scan_ff             <= scan_in;
      chk_idx_ff          <= chk_idx_in;
      chk_vld_ff          <= chk_vld_in;
      found_ff            <= found_in;
      cur_ff              <= cur_in;
      fwd_ff              <= fwd_in;
      freed_ff            <= freed_in;
      mul_op_ff           <= mul_op_in;
      rsp_status_ff       <= rsp_status_in;
      rsp_block_index_ff  <= rsp_block_index_in;
      rsp_byte_address_ff <= rsp_byte_address_in;
      rsp_at_end_ff       <= rsp_at_end_in;
      rsp_freed_count_ff  <= rsp_freed_count_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_index  = rsp_block_index_ff;
   assign rsp_byte_address = rsp_byte_address_ff;
   assign rsp_at_end       = rsp_at_end_ff;
   assign rsp_freed_count  = rsp_freed_count_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result strobe without a finishing command");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_status == ST_OK) || (rsp_status == ST_NO_FREE) ||
                      (rsp_status == ST_BAD)))
      else $error("undefined status code");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK)) |->
         ((rsp_block_index == '0) && (rsp_byte_address == '0) &&
          !rsp_at_end && (rsp_freed_count == '0)))
      else $error("failed command returned non-zero fields");

endmodule

>>> tb/testbench.sv
// Testbench for the block chain allocation table: predicted table, command driver and checks.
module testbench;
   import bcat_pkg::*;

   localparam int DEPTH          = 64;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SHOWN_MAX      = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BLK_W-1:0]    block_index;
      logic [ADDR_W-1:0]   byte_address;
      logic                at_end;
      logic [FREED_W-1:0]  freed_count;
   } result_word_type;

   // Predicted table plus queue of result words still owed by the block.
   class chain_table_scoreboard;
      logic [ENTRY_W-1:0] entry [DEPTH];
      logic [BLK_W-1:0]   tail;
      bit                 tail_open;
      logic [ACT_W-1:0]   active;
      logic [BPB_W-1:0]   bpb;
      result_word_type    owed [$];
      int                 file_heads [$];
      int                 errors;

      function new();
         foreach (entry[i]) entry[i] = ENT_FREE;
         tail      = '0;
         tail_open = 0;
         active    = ACTIVE_RESET;
         bpb       = BPB_RESET;
         errors    = 0;
      endfunction

      function int used();
         return (active < DEPTH) ? int'(active) : DEPTH;
      endfunction

      function logic [ADDR_W-1:0] block_addr(int idx);
         logic [31:0] p;
         p = idx * bpb;
         return p[ADDR_W-1:0];
      endfunction

      function bit tail_live();
         return tail_open && (tail < used());
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ACTIVE_BLOCKS:   active = data[ACT_W-1:0];
            CSR_BYTES_PER_BLOCK: bpb    = data[BPB_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_command(logic [KIND_W-1:0] kind, logic start_new,
                                 logic [BLK_W-1:0] blk);
         result_word_type    r;
         int                 n, i, found, cur, freed;
         bit                 done;
         logic [ENTRY_W-1:0] e;
         r = '0;
         n = used();
         case (kind)
            OP_APPEND: begin
               if (!start_new && !tail_live()) begin
                  r.status = ST_BAD;
               end else begin
                  found = n;
                  for (i = 0; i < n; i++)
                     if (found == n && entry[i] == ENT_FREE) found = i;
                  if (found >= n) begin
                     r.status = ST_NO_FREE;
                  end else begin
                     entry[found] = ENT_ALLOC;
                     if (!start_new) entry[tail] = ENTRY_W'(found);
                     else file_heads.push_back(found);
                     if (file_heads.size() > DEPTH) void'(file_heads.pop_front());
                     tail           = BLK_W'(found);
                     tail_open      = 1;
                     r.block_index  = BLK_W'(found);
                     r.byte_address = block_addr(found);
                  end
               end
            end
            OP_CLOSE: begin
               if (!tail_live()) begin
                  r.status = ST_BAD;
               end else begin
                  entry[tail]    = ENT_EOF;
                  tail_open      = 0;
                  r.block_index  = tail;
                  r.byte_address = block_addr(tail);
               end
            end
            OP_FOLLOW: begin
               if (blk >= n) begin
                  r.status = ST_BAD;
               end else begin
                  e = entry[blk];
                  if (e == ENT_EOF) begin
                     r.at_end = 1'b1;
                  end else if (e < ENT_ALLOC) begin
                     r.block_index  = e[BLK_W-1:0];
                     r.byte_address = block_addr(e[BLK_W-1:0]);
                  end
               end
            end
            default: begin
               if (blk >= n) begin
                  r.status = ST_BAD;
               end else begin
                  cur   = blk;
                  freed = 0;
                  done  = 0;
                  // walk is bounded by n steps even if links form a loop
                  for (i = 0; i < n && !done; i++) begin
                     e = entry[cur];
                     if (e == ENT_FREE) begin
                        done = 1;
                     end else begin
                        entry[cur] = ENT_FREE;
                        freed++;
                        if (tail_open && cur == tail) tail_open = 0;
                        if (e >= ENT_ALLOC || e >= n) done = 1;
                        else cur = e;
                     end
                  end
                  r.freed_count = FREED_W'(freed);
               end
            end
         endcase
         owed.push_back(r);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [BLK_W-1:0] idx,
                                 logic [ADDR_W-1:0] addr, logic at_end,
                                 logic [FREED_W-1:0] freed);
         result_word_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= SHOWN_MAX)
               $display("%0t: result word with nothing outstanding: st=%0d blk=%0d",
                        $time, status, idx);
         end else begin
            want = owed.pop_front();
            if (want.status !== status || want.block_index !== idx ||
                want.byte_address !== addr || want.at_end !== at_end ||
                want.freed_count !== freed) begin
               errors++;
               if (errors <= SHOWN_MAX)
                  $display("%0t: wrong word: want st=%0d blk=%0d addr=%0h end=%0d freed=%0d %s",
                           $time, want.status, want.block_index, want.byte_address,
                           want.at_end, want.freed_count,
                           $sformatf("got st=%0d blk=%0d addr=%0h end=%0d freed=%0d",
                                     status, idx, addr, at_end, freed));
            end
         end
      endfunction
   endclass

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  start         = 1'b0;
   logic                  busy;
   logic [KIND_W-1:0]     req_kind      = OP_FOLLOW;
   logic                  req_start_new = 1'b0;
   logic [BLK_W-1:0]      req_block     = '0;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic [BLK_W-1:0]      rsp_block_index;
   logic [ADDR_W-1:0]     rsp_byte_address;
   logic                  rsp_at_end;
   logic [FREED_W-1:0]    rsp_freed_count;
   logic                  csr_wr_en     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index     = CSR_ACTIVE_BLOCKS;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   chain_table_scoreboard sb;
   int                    idle_pct = 0;
   int                    quiet_cycles = 0;

   block_chain_allocation_table u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_start_new    (req_start_new),
      .req_block        (req_block),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_block_index  (rsp_block_index),
      .rsp_byte_address (rsp_byte_address),
      .rsp_at_end       (rsp_at_end),
      .rsp_freed_count  (rsp_freed_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor and watchdog: everything sampled as it stood before the edge
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_wr_en) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_command(req_kind, req_start_new, req_block);
         if (rsp_strobe)
            sb.check_result(rsp_status, rsp_block_index, rsp_byte_address,
                            rsp_at_end, rsp_freed_count);
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic issue_command(input logic [KIND_W-1:0] kind, input logic start_new,
                                input logic [BLK_W-1:0] blk);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_kind      <= kind;
      req_start_new <= start_new;
      req_block     <= blk;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0 || busy) @(posedge clock);
   endtask

   task automatic program_geometry(input logic [ACT_W-1:0] active,
                                   input logic [BPB_W-1:0] bpb);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_ACTIVE_BLOCKS;
      csr_wdata <= CSR_DATA_W'(active);
      @(posedge clock);
      csr_index <= CSR_BYTES_PER_BLOCK;
      csr_wdata <= bpb;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [BLK_W-1:0] pick_block();
      int n;
      n = sb.used();
      if (n > 0 && $urandom_range(3) != 0) return BLK_W'($urandom_range(n - 1));
      return BLK_W'($urandom_range(63));
   endfunction

   task automatic run_directed();
      // reset geometry: nothing open yet
      issue_command(OP_CLOSE, 1'b1, 6'd63);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      issue_command(OP_APPEND, 1'b1, 6'd63);
      issue_command(OP_FOLLOW, 1'b0, 6'd0);
      wait_idle();
      program_geometry(7'd4, 11'd1024);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      issue_command(OP_APPEND, 1'b1, 6'd0);   // new file leaves block 2 unlinked
      issue_command(OP_APPEND, 1'b0, 6'd0);   // table full
      issue_command(OP_FOLLOW, 1'b1, 6'd0);
      issue_command(OP_FOLLOW, 1'b0, 6'd2);
      issue_command(OP_CLOSE, 1'b0, 6'd0);
      issue_command(OP_FOLLOW, 1'b0, 6'd3);
      issue_command(OP_FOLLOW, 1'b0, 6'd4);
      issue_command(OP_DELETE, 1'b0, 6'd4);
      issue_command(OP_DELETE, 1'b1, 6'd0);
      issue_command(OP_FOLLOW, 1'b0, 6'd1);
      issue_command(OP_DELETE, 1'b0, 6'd1);
      issue_command(OP_CLOSE, 1'b0, 6'd0);
      issue_command(OP_DELETE, 1'b0, 6'd3);
      issue_command(OP_APPEND, 1'b1, 6'd0);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      // shrink so the open tail falls outside the table
      wait_idle();
      program_geometry(7'd2, 11'd2047);
      issue_command(OP_CLOSE, 1'b0, 6'd0);
      issue_command(OP_APPEND, 1'b0, 6'd0);
      issue_command(OP_DELETE, 1'b0, 6'd0);
      wait_idle();
      program_geometry(7'd0, 11'd0);
      issue_command(OP_APPEND, 1'b1, 6'd0);
      issue_command(OP_FOLLOW, 1'b0, 6'd0);
   endtask

   task automatic run_random(input int count);
      int               k, p, j;
      logic [BLK_W-1:0] blk;
      for (k = 0; k < count; k++) begin
         p = $urandom_range(99);
         if (p < 8) begin
            issue_command(KIND_W'($urandom_range(3)), 1'($urandom_range(1)),
                          BLK_W'($urandom_range(63)));
         end else if (p < 18) begin
            issue_command(OP_APPEND, 1'b1, BLK_W'($urandom_range(63)));
         end else if (p < 50) begin
            issue_command(OP_APPEND, 1'b0, BLK_W'($urandom_range(63)));
         end else if (p < 60) begin
            issue_command(OP_CLOSE, 1'($urandom_range(1)), BLK_W'($urandom_range(63)));
         end else if (p < 78) begin
            issue_command(OP_FOLLOW, 1'($urandom_range(1)), pick_block());
         end else begin
            // mostly delete whole files from their first block
            if (sb.file_heads.size() != 0 && $urandom_range(3) != 0) begin
               j   = $urandom_range(sb.file_heads.size() - 1);
               blk = BLK_W'(sb.file_heads[j]);
               sb.file_heads.delete(j);
            end else begin
               blk = pick_block();
            end
            issue_command(OP_DELETE, 1'($urandom_range(1)), blk);
         end
      end
   endtask

   initial begin
      int               ph;
      logic [ACT_W-1:0] act_set [9];
      logic [BPB_W-1:0] bpb_set [9];
      int               words [9];
      act_set = '{7'd40, 7'd64, 7'd1, 7'd2, 7'd127, 7'd0, 7'd8, 7'd33, 7'd64};
      bpb_set = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd1365,
                  11'd5, 11'd682, 11'd1023, 11'd1};
      words   = '{220, 220, 150, 200, 220, 60, 220, 220, 220};
      sb = new();
      repeat (11) @(posedge clock);
      reset    <= 1'b0;
      idle_pct = 19;
      run_directed();
      for (ph = 0; ph < 9; ph++) begin
         idle_pct = (ph < 3) ? 19 : ((ph < 6) ? 70 : 0);
         wait_idle();
         program_geometry(act_set[ph], bpb_set[ph]);
         run_random(words[ph]);
      end
      wait_idle();
      repeat (80) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
